### sv/lcw_pkg.sv
// types and constants shared by the lcw decompressor
`timescale 1ns / 1ps
`default_nettype none

package lcw_pkg;

   typedef struct packed {
      logic       op;
      logic [7:0] src_byte;
   } req_type;

   typedef struct packed {
      logic        out_valid;
      logic [7:0]  out_byte;
      logic        want_byte;
      logic        finished;
      logic [16:0] out_length;
      logic [1:0]  fault;
   } rsp_type;

   typedef enum logic [7:0] {
      PH_CMD  = 8'b0000_0001,
      PH_ARG1 = 8'b0000_0010,
      PH_ARG2 = 8'b0000_0100,
      PH_ARG3 = 8'b0000_1000,
      PH_ARG4 = 8'b0001_0000,
      PH_LIT  = 8'b0010_0000,
      PH_EMIT = 8'b0100_0000,
      PH_HELD = 8'b1000_0000
   } phase_type;

   localparam logic       OP_BYTE = 1'b0;
   localparam logic       OP_TICK = 1'b1;

   localparam logic [1:0] FAULT_NONE      = 2'd0;
   localparam logic [1:0] FAULT_UNWRITTEN = 2'd1;
   localparam logic [1:0] FAULT_OVERFLOW  = 2'd2;
   localparam logic [1:0] FAULT_AFTER_END = 2'd3;

   localparam logic [7:0] CMD_END  = 8'h80;
   localparam logic [7:0] CMD_FILL = 8'hFE;
   localparam logic [7:0] CMD_LONG = 8'hFF;

   localparam logic [15:0] COPY_BIAS = 16'd3;

endpackage

`default_nettype wire

### sv/lcw_decompressor.sv
// lcw (format80) stream decoder with history memory
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  payload               handshake
// req_      in         op, src_byte          req_valid / req_stall
// rsp_      out        status and out_byte   rsp_valid / rsp_stall
//
// one item accepted per cycle while req_stall is low; its result item is registered
//   in the byte stage and then in the output register (parse/read at accept, then
//   byte select, history write and output register together)
// the rate is set by the single history memory port pair: one read at accept,
//   one write as the byte stage advances, with a bypass for a copy of the byte just written
// reset clears all parser state; history contents stay undefined until written
// req_stall rises only when both the byte stage and the output register are full

module lcw_decompressor #(
   parameter int HISTORY_DEPTH = 65536
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  lcw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output lcw_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(HISTORY_DEPTH);

   // parser state
   lcw_pkg::phase_type phase_ff, phase_in;
   logic [16:0] write_pos_ff, write_pos_in;
   logic [7:0]  command_ff, command_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] copy_pos_ff, copy_pos_in;
   logic [7:0]  fill_value_ff, fill_value_in;
   logic [7:0]  low_part_ff, low_part_in;
   logic        done_ff, done_in;
   logic [1:0]  fault_ff, fault_in;

   // history memory
   logic [7:0]  hist_mem [HISTORY_DEPTH];
   logic [7:0]  rd_data_ff;

   // byte stage
   logic          byte_valid_ff, byte_valid_in;
   logic          byte_emit_ff, byte_emit_in;
   logic          byte_fill_ff, byte_fill_in;
   logic [7:0]    byte_fill_val_ff, byte_fill_val_in;
   logic          byte_fwd_ff, byte_fwd_in;
   logic [7:0]    byte_fwd_data_ff, byte_fwd_data_in;
   logic [AW-1:0] byte_addr_ff, byte_addr_in;
   logic          byte_want_ff, byte_want_in;
   logic          byte_done_ff, byte_done_in;
   logic [16:0]   byte_len_ff, byte_len_in;
   logic [1:0]    byte_fault_ff, byte_fault_in;
   logic [7:0]    byte_value;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   lcw_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          byte_adv;
   logic          emit;
   logic          emit_fill;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [15:0]   rem_dec;
   logic [11:0]   back_dist;

   assign byte_adv  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = byte_valid_ff && !byte_adv;
   assign accept    = req_valid && !req_stall;
   assign rem_dec   = remaining_ff - 16'd1;
   assign back_dist = {command_ff[3:0], req_data.src_byte};
   assign rd_addr   = copy_pos_ff[AW-1:0];

   // parser and tick logic, all control state resolves at accept
   always_comb begin
      phase_in      = phase_ff;
      write_pos_in  = write_pos_ff;
      command_in    = command_ff;
      remaining_in  = remaining_ff;
      copy_pos_in   = copy_pos_ff;
      fill_value_in = fill_value_ff;
      low_part_in   = low_part_ff;
      done_in       = done_ff;
      fault_in      = fault_ff;
      emit          = 1'b0;
      emit_fill     = 1'b0;
      if (accept && fault_ff == lcw_pkg::FAULT_NONE) begin
         if (done_ff) begin
            if (req_data.op == lcw_pkg::OP_BYTE) begin
               fault_in = lcw_pkg::FAULT_AFTER_END;
            end
         end else if (req_data.op == lcw_pkg::OP_BYTE) begin
            unique case (phase_ff)
               lcw_pkg::PH_CMD: begin
                  command_in = req_data.src_byte;
                  if (!req_data.src_byte[7]) begin
                     phase_in = lcw_pkg::PH_ARG1;
                  end else if (req_data.src_byte == lcw_pkg::CMD_END) begin
                     done_in = 1'b1;
                  end else if (!req_data.src_byte[6]) begin
                     remaining_in = {10'd0, req_data.src_byte[5:0]};
                     phase_in     = lcw_pkg::PH_LIT;
                  end else begin
                     phase_in = lcw_pkg::PH_ARG1;
                  end
               end
               lcw_pkg::PH_ARG1: begin
                  if (!command_ff[7]) begin
                     // relative copy: distance back from the write position
                     copy_pos_in  = write_pos_ff[15:0] - {4'd0, back_dist};
                     remaining_in = {12'd0, command_ff[7:4]} + lcw_pkg::COPY_BIAS;
                     phase_in     = lcw_pkg::PH_EMIT;
                  end else begin
                     low_part_in = req_data.src_byte;
                     phase_in    = lcw_pkg::PH_ARG2;
                  end
               end
               lcw_pkg::PH_ARG2: begin
                  if (command_ff == lcw_pkg::CMD_FILL || command_ff == lcw_pkg::CMD_LONG) begin
                     remaining_in = {req_data.src_byte, low_part_ff};
                     phase_in     = lcw_pkg::PH_ARG3;
                  end else begin
                     copy_pos_in  = {req_data.src_byte, low_part_ff};
                     remaining_in = {10'd0, command_ff[5:0]} + lcw_pkg::COPY_BIAS;
                     phase_in     = lcw_pkg::PH_EMIT;
                  end
               end
               lcw_pkg::PH_ARG3: begin
                  if (command_ff == lcw_pkg::CMD_FILL) begin
                     fill_value_in = req_data.src_byte;
                     phase_in = (remaining_ff != 16'd0) ? lcw_pkg::PH_EMIT : lcw_pkg::PH_CMD;
                  end else begin
                     low_part_in = req_data.src_byte;
                     phase_in    = lcw_pkg::PH_ARG4;
                  end
               end
               lcw_pkg::PH_ARG4: begin
                  copy_pos_in = {req_data.src_byte, low_part_ff};
                  phase_in = (remaining_ff != 16'd0) ? lcw_pkg::PH_EMIT : lcw_pkg::PH_CMD;
               end
               lcw_pkg::PH_LIT: begin
                  fill_value_in = req_data.src_byte;
                  phase_in      = lcw_pkg::PH_HELD;
               end
               default: begin
                  // emitting or holding a literal: byte dropped
               end
            endcase
         end else if (phase_ff == lcw_pkg::PH_EMIT || phase_ff == lcw_pkg::PH_HELD) begin
            priority if (write_pos_ff >= 17'(HISTORY_DEPTH)) begin
               fault_in = lcw_pkg::FAULT_OVERFLOW;
            end else if (phase_ff == lcw_pkg::PH_HELD || command_ff == lcw_pkg::CMD_FILL) begin
               emit      = 1'b1;
               emit_fill = 1'b1;
            end else if ({1'b0, copy_pos_ff} >= write_pos_ff) begin
               fault_in = lcw_pkg::FAULT_UNWRITTEN;
            end else begin
               emit        = 1'b1;
               copy_pos_in = copy_pos_ff + 16'd1;
            end
            if (emit) begin
               write_pos_in = write_pos_ff + 17'd1;
               remaining_in = rem_dec;
               if (phase_ff == lcw_pkg::PH_HELD) begin
                  phase_in = (rem_dec != 16'd0) ? lcw_pkg::PH_LIT : lcw_pkg::PH_CMD;
               end else if (rem_dec == 16'd0) begin
                  phase_in = lcw_pkg::PH_CMD;
               end
            end
         end
      end
   end

   assign rd_en = emit && !emit_fill;

   // byte stage loads on accept; bypass when the source is the byte written now
   always_comb begin
      byte_emit_in     = emit;
      byte_fill_in     = emit_fill;
      byte_fill_val_in = fill_value_ff;
      byte_fwd_in      = byte_valid_ff && byte_emit_ff && byte_adv && (byte_addr_ff == rd_addr);
      byte_fwd_data_in = byte_value;
      byte_addr_in     = write_pos_ff[AW-1:0];
      byte_done_in     = done_in;
      byte_len_in      = write_pos_in;
      byte_fault_in    = fault_in;
      byte_want_in     = (fault_in == lcw_pkg::FAULT_NONE) && !done_in &&
                         phase_in != lcw_pkg::PH_EMIT && phase_in != lcw_pkg::PH_HELD;
      if (accept) begin
         byte_valid_in = 1'b1;
      end else if (byte_adv) begin
         byte_valid_in = 1'b0;
      end else begin
         byte_valid_in = byte_valid_ff;
      end
   end

   always_comb begin
      if (byte_fill_ff) begin
         byte_value = byte_fill_val_ff;
      end else if (byte_fwd_ff) begin
         byte_value = byte_fwd_data_ff;
      end else begin
         byte_value = rd_data_ff;
      end
   end

   // output register
   always_comb begin
      rsp_data_in.out_valid  = byte_emit_ff;
      rsp_data_in.out_byte   = byte_emit_ff ? byte_value : 8'd0;
      rsp_data_in.want_byte  = byte_want_ff;
      rsp_data_in.finished   = byte_done_ff;
      rsp_data_in.out_length = byte_len_ff;
      rsp_data_in.fault      = byte_fault_ff;
      rsp_valid_in           = byte_adv ? byte_valid_ff : rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
      if (byte_valid_ff && byte_emit_ff && byte_adv) begin
         hist_mem[byte_addr_ff] <= byte_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= lcw_pkg::PH_CMD;
         write_pos_ff  <= 17'd0;
         command_ff    <= 8'd0;
         remaining_ff  <= 16'd0;
         copy_pos_ff   <= 16'd0;
         fill_value_ff <= 8'd0;
         low_part_ff   <= 8'd0;
         done_ff       <= 1'b0;
         fault_ff      <= lcw_pkg::FAULT_NONE;
         byte_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         write_pos_ff  <= write_pos_in;
         command_ff    <= command_in;
         remaining_ff  <= remaining_in;
         copy_pos_ff   <= copy_pos_in;
         fill_value_ff <= fill_value_in;
         low_part_ff   <= low_part_in;
         done_ff       <= done_in;
         fault_ff      <= fault_in;
         byte_valid_ff <= byte_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_emit_ff     <= byte_emit_in;
         byte_fill_ff     <= byte_fill_in;
         byte_fill_val_ff <= byte_fill_val_in;
         byte_fwd_ff      <= byte_fwd_in;
         byte_fwd_data_ff <= byte_fwd_data_in;
         byte_addr_ff     <= byte_addr_in;
         byte_want_ff     <= byte_want_in;
         byte_done_ff     <= byte_done_in;
         byte_len_ff      <= byte_len_in;
         byte_fault_ff    <= byte_fault_in;
      end
      if (byte_adv && byte_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

### tb/lcw_decompressor_test.sv
// self-checking testbench for the lcw stream decoder: directed and random streams
`timescale 1ns / 1ps

module lcw_decompressor_test;

   // smallest legal window
   localparam int DEPTH       = 4096;
   localparam int HALF_PERIOD = 5;
   localparam int ITEM_TARGET = 1025;
   localparam int CYCLE_LIMIT = 1000000;
   // long receiver hold-off after this many result items
   localparam int HOLD_AT     = 150;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic             drain;   // wait for every outstanding result before offering
      lcw_pkg::req_type item;
   } stim_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   lcw_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   lcw_pkg::rsp_type rsp_data;

   // stimulus and expected decoder output
   stim_type         stream_q [$];
   lcw_pkg::rsp_type decoded_q [$];
   int               total_items  = 0;
   int               planned_len  = 0;   // decoded length the generated stream reaches

   // handshake bookkeeping, updated at the rising edge
   logic req_took     = 1'b0;
   logic rsp_took     = 1'b0;
   int   accepted     = 0;
   int   results_seen = 0;
   int   mismatches   = 0;
   int   cycle_count  = 0;

   // sender and receiver idling
   int   send_gap   = 0;
   bit   send_burst = 1'b0;
   int   recv_wait  = 0;
   bit   recv_burst = 1'b0;
   int   hold_left  = 0;

   // decoder state as the predictor sees it
   logic [7:0]         hist [DEPTH];
   logic [16:0]        wr_len     = '0;
   lcw_pkg::phase_type phase      = lcw_pkg::PH_CMD;
   logic [7:0]         cmd_q      = '0;
   logic [15:0]        run_left   = '0;
   logic [15:0]        src_pos    = '0;
   logic [7:0]         fill_byte  = '0;
   logic [7:0]         arg_low    = '0;
   logic               ended      = 1'b0;
   logic [1:0]         fault_code = lcw_pkg::FAULT_NONE;

   lcw_decompressor #(
      .HISTORY_DEPTH(DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // command parser: one compressed byte
   function automatic void parse_byte(input logic [7:0] b);
      case (phase)
         lcw_pkg::PH_CMD: begin
            cmd_q = b;
            if (!b[7]) begin
               phase = lcw_pkg::PH_ARG1;        // relative copy, distance low byte next
            end else if (b == lcw_pkg::CMD_END) begin
               ended = 1'b1;
            end else if (!b[6]) begin
               run_left = 16'(b[5:0]);          // literal run
               phase    = lcw_pkg::PH_LIT;
            end else begin
               phase = lcw_pkg::PH_ARG1;
            end
         end
         lcw_pkg::PH_ARG1: begin
            if (!cmd_q[7]) begin
               // distance counts back from the current length, wraps at 16 bits
               src_pos  = wr_len[15:0] - {4'h0, cmd_q[3:0], b};
               run_left = 16'(cmd_q[6:4]) + lcw_pkg::COPY_BIAS;
               phase    = lcw_pkg::PH_EMIT;
            end else begin
               arg_low = b;
               phase   = lcw_pkg::PH_ARG2;
            end
         end
         lcw_pkg::PH_ARG2: begin
            if (cmd_q == lcw_pkg::CMD_FILL || cmd_q == lcw_pkg::CMD_LONG) begin
               run_left = {b, arg_low};
               phase    = lcw_pkg::PH_ARG3;
            end else begin
               src_pos  = {b, arg_low};
               run_left = 16'(cmd_q[5:0]) + lcw_pkg::COPY_BIAS;
               phase    = lcw_pkg::PH_EMIT;
            end
         end
         lcw_pkg::PH_ARG3: begin
            if (cmd_q == lcw_pkg::CMD_FILL) begin
               fill_byte = b;
               phase     = (run_left != 0) ? lcw_pkg::PH_EMIT : lcw_pkg::PH_CMD;
            end else begin
               arg_low = b;
               phase   = lcw_pkg::PH_ARG4;
            end
         end
         lcw_pkg::PH_ARG4: begin
            src_pos = {b, arg_low};
            phase   = (run_left != 0) ? lcw_pkg::PH_EMIT : lcw_pkg::PH_CMD;
         end
         lcw_pkg::PH_LIT: begin
            fill_byte = b;
            phase     = lcw_pkg::PH_HELD;
         end
         default: begin
            // emitting or holding a literal: byte dropped
         end
      endcase
   endfunction

   // one tick: returns 1 when a decoded byte comes out
   function automatic logic emit_byte(output logic [7:0] v);
      v = '0;
      if (phase != lcw_pkg::PH_EMIT && phase != lcw_pkg::PH_HELD) return 1'b0;
      if (int'(wr_len) >= DEPTH) begin
         fault_code = lcw_pkg::FAULT_OVERFLOW;
         return 1'b0;
      end
      if (phase == lcw_pkg::PH_HELD || cmd_q == lcw_pkg::CMD_FILL) begin
         v = fill_byte;
      end else begin
         if ({1'b0, src_pos} >= wr_len) begin
            fault_code = lcw_pkg::FAULT_UNWRITTEN;
            return 1'b0;
         end
         v       = hist[int'(src_pos) % DEPTH];
         src_pos = src_pos + 16'd1;
      end
      hist[int'(wr_len) % DEPTH] = v;
      wr_len   = wr_len + 17'd1;
      run_left = run_left - 16'd1;
      if (phase == lcw_pkg::PH_HELD)
         phase = (run_left != 0) ? lcw_pkg::PH_LIT : lcw_pkg::PH_CMD;
      else if (run_left == 0)
         phase = lcw_pkg::PH_CMD;
      return 1'b1;
   endfunction

   function automatic lcw_pkg::rsp_type decode_step(input lcw_pkg::req_type r);
      lcw_pkg::rsp_type o;
      logic [7:0]       v;
      logic             emitted;
      v       = '0;
      emitted = 1'b0;
      // a fault freezes everything
      if (fault_code == lcw_pkg::FAULT_NONE) begin
         if (ended) begin
            if (r.op == lcw_pkg::OP_BYTE) fault_code = lcw_pkg::FAULT_AFTER_END;
         end else if (r.op == lcw_pkg::OP_BYTE) begin
            parse_byte(r.src_byte);
         end else begin
            emitted = emit_byte(v);
         end
      end
      o.out_valid  = emitted;
      o.out_byte   = emitted ? v : 8'h00;
      o.want_byte  = (fault_code == lcw_pkg::FAULT_NONE) && !ended &&
                     phase != lcw_pkg::PH_EMIT && phase != lcw_pkg::PH_HELD;
      o.finished   = ended;
      o.out_length = wr_len;
      o.fault      = fault_code;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // stream generation
   // ---------------------------------------------------------------------

   task automatic queue_item(input logic op, input logic [7:0] b, input logic drain = 1'b0);
      stim_type e;
      e.drain         = drain;
      e.item.op       = op;
      e.item.src_byte = b;
      stream_q.push_back(e);
      total_items++;
   endtask

   // byte the parser waits for; an idle tick in front of it changes nothing
   task automatic queue_src(input logic [7:0] b);
      if ($urandom_range(0, 9) == 0) queue_item(lcw_pkg::OP_TICK, 8'($urandom));
      queue_item(lcw_pkg::OP_BYTE, b);
   endtask

   // n emitting ticks; a byte slipped in between two of them is dropped
   task automatic queue_ticks(input int n);
      for (int i = 0; i < n; i++) begin
         queue_item(lcw_pkg::OP_TICK, 8'($urandom));
         if (i < n - 1 && $urandom_range(0, 7) == 0)
            queue_item(lcw_pkg::OP_BYTE, 8'($urandom));
      end
      planned_len += n;
   endtask

   // one well-formed command with random content, never faulting
   task automatic queue_command();
      int kind;
      int n;
      int back;
      int off;
      kind = $urandom_range(0, 9);
      // copies need something already decoded
      if (planned_len == 0 && kind >= 3 && kind != 7 && kind != 9) kind = 0;
      case (kind)
         0, 1, 2: begin
            n = ($urandom_range(0, 7) == 0) ? 63 : $urandom_range(1, 8);
            queue_src(8'h80 | 8'(n));
            for (int i = 0; i < n; i++) begin
               queue_src(8'($urandom));
               // a second byte while the literal is held is dropped
               if ($urandom_range(0, 7) == 0) queue_item(lcw_pkg::OP_BYTE, 8'($urandom));
               queue_item(lcw_pkg::OP_TICK, 8'($urandom));
            end
            planned_len += n;
         end
         3, 4: begin
            n = $urandom_range(0, 7);
            // short distances give overlapping copies
            if ($urandom_range(0, 3) == 0)
               back = $urandom_range(1, (planned_len < 4) ? planned_len : 4);
            else
               back = $urandom_range(1, (planned_len < 4095) ? planned_len : 4095);
            queue_src({1'b0, 3'(n), 4'(back >> 8)});
            queue_src(8'(back));
            queue_ticks(n + 3);
         end
         5, 6: begin
            n   = ($urandom_range(0, 5) == 0) ? 61 : $urandom_range(0, 12);
            off = $urandom_range(0, planned_len - 1);
            queue_src(8'hC0 | 8'(n));
            queue_src(8'(off));
            queue_src(8'(off >> 8));
            queue_ticks(n + 3);
         end
         7: begin
            n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24);
            queue_src(lcw_pkg::CMD_FILL);
            queue_src(8'(n));
            queue_src(8'(n >> 8));
            queue_src(8'($urandom));
            queue_ticks(n);
         end
         8: begin
            n   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24);
            off = $urandom_range(0, planned_len - 1);
            queue_src(lcw_pkg::CMD_LONG);
            queue_src(8'(n));
            queue_src(8'(n >> 8));
            queue_src(8'(off));
            queue_src(8'(off >> 8));
            queue_ticks(n);
         end
         default: begin
            // idle ticks between commands
            repeat ($urandom_range(1, 3)) queue_item(lcw_pkg::OP_TICK, 8'($urandom));
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // driver: items from stream_q, a drawn gap after each
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      stim_type e;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         // stalled, item stays on the port
      end else if (send_gap != 0) begin
         req_valid <= 1'b0;
         send_gap--;
      end else if (stream_q.size() != 0 && !(stream_q[0].drain && decoded_q.size() != 0)) begin
         e = stream_q.pop_front();
         req_data  <= e.item;
         req_valid <= 1'b1;
         if ($urandom_range(0, 39) == 0) send_burst = ($urandom_range(0, 2) == 0);
         send_gap = send_burst ? 0 : $urandom_range(0, 15);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // receiver: stall drawn per result item, one long hold-off
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_took) begin
            if ($urandom_range(0, 39) == 0) recv_burst = ($urandom_range(0, 2) == 0);
            recv_wait = recv_burst ? 0 : $urandom_range(0, 15);
            // long hold-off so the block fills up and stalls its input
            if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (recv_wait != 0) begin
            rsp_stall <= 1'b1;
            recv_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic report(input string what, input logic [16:0] want_v, input logic [16:0] got_v);
      $display("mismatch at cycle %0d: %s expected %0h got %0h",
               cycle_count, what, want_v, got_v);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // monitor: predict on every accepted item, check every result item
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      lcw_pkg::rsp_type want;
      cycle_count <= cycle_count + 1;
      req_took = !reset && req_valid && !req_stall;
      rsp_took = !reset && rsp_valid && !rsp_stall;
      if (req_took) begin
         decoded_q.push_back(decode_step(req_data));
         accepted++;
      end
      if (rsp_took) begin
         results_seen++;
         if (decoded_q.size() == 0) begin
            report("result with none pending, out_length", '0, rsp_data.out_length);
         end else begin
            want = decoded_q.pop_front();
            if (rsp_data.out_valid !== want.out_valid)
               report("out_valid", 17'(want.out_valid), 17'(rsp_data.out_valid));
            if (rsp_data.out_byte !== want.out_byte)
               report("out_byte", 17'(want.out_byte), 17'(rsp_data.out_byte));
            if (rsp_data.want_byte !== want.want_byte)
               report("want_byte", 17'(want.want_byte), 17'(rsp_data.want_byte));
            if (rsp_data.finished !== want.finished)
               report("finished", 17'(want.finished), 17'(rsp_data.finished));
            if (rsp_data.out_length !== want.out_length)
               report("out_length", want.out_length, rsp_data.out_length);
            if (rsp_data.fault !== want.fault)
               report("fault", 17'(want.fault), 17'(rsp_data.fault));
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus, reset and end of run
   // ---------------------------------------------------------------------
   initial begin
      int back;
      int n;

      // directed opening
      queue_item(lcw_pkg::OP_TICK, 8'h00);            // tick while a byte is awaited
      queue_item(lcw_pkg::OP_BYTE, 8'h81);            // single literal, all ones
      queue_item(lcw_pkg::OP_BYTE, 8'hFF);
      queue_item(lcw_pkg::OP_TICK, 8'h00);
      queue_item(lcw_pkg::OP_BYTE, lcw_pkg::CMD_FILL); // fill of two zero bytes
      queue_item(lcw_pkg::OP_BYTE, 8'h02);
      queue_item(lcw_pkg::OP_BYTE, 8'h00);
      queue_item(lcw_pkg::OP_BYTE, 8'h00);
      queue_item(lcw_pkg::OP_TICK, 8'h00);
      queue_item(lcw_pkg::OP_TICK, 8'h00);
      queue_item(lcw_pkg::OP_BYTE, lcw_pkg::CMD_FILL); // zero-count fill
      queue_item(lcw_pkg::OP_BYTE, 8'h00);
      queue_item(lcw_pkg::OP_BYTE, 8'h00);
      queue_item(lcw_pkg::OP_BYTE, 8'h5A);
      queue_item(lcw_pkg::OP_BYTE, lcw_pkg::CMD_LONG); // zero-count long copy
      queue_item(lcw_pkg::OP_BYTE, 8'h00);
      queue_item(lcw_pkg::OP_BYTE, 8'h00);
      queue_item(lcw_pkg::OP_BYTE, 8'h00);
      queue_item(lcw_pkg::OP_BYTE, 8'h00);
      queue_item(lcw_pkg::OP_BYTE, 8'h00);            // overlapping copy, distance one
      queue_item(lcw_pkg::OP_BYTE, 8'h01);
      queue_item(lcw_pkg::OP_TICK, 8'h00);
      queue_item(lcw_pkg::OP_BYTE, 8'hAA);            // dropped while emitting
      queue_item(lcw_pkg::OP_TICK, 8'h00);
      queue_item(lcw_pkg::OP_TICK, 8'h00);
      planned_len = 6;

      // random part; sender first waits for an empty pipe
      queue_item(lcw_pkg::OP_TICK, 8'($urandom), 1'b1);
      while (total_items < ITEM_TARGET && planned_len < DEPTH - 300) queue_command();

      // faults and the end are sticky, so one of them closes the run
      case ($urandom_range(0, 1))
         0: begin
            queue_item(lcw_pkg::OP_BYTE, lcw_pkg::CMD_END, 1'b1);
            queue_item(lcw_pkg::OP_TICK, 8'($urandom));  // ticks after the end give nothing
            queue_item(lcw_pkg::OP_TICK, 8'($urandom));
            queue_item(lcw_pkg::OP_BYTE, 8'($urandom));  // byte after the end
         end
         default: begin
            queue_item(lcw_pkg::OP_TICK, 8'($urandom), 1'b1);
            case ($urandom_range(0, 2))
               0: begin
                  // zero distance points at the next unwritten byte
                  queue_src({1'b0, 3'($urandom), 4'h0});
                  queue_src(8'h00);
               end
               1: begin
                  // distance reaching before the start of the output
                  back = $urandom_range(planned_len + 1, 4095);
                  queue_src({1'b0, 3'($urandom), 4'(back >> 8)});
                  queue_src(8'(back));
               end
               default: begin
                  // absolute offset not yet written
                  n = $urandom_range(planned_len, 65535);
                  queue_src(lcw_pkg::CMD_LONG);
                  queue_src(8'h05);
                  queue_src(8'h00);
                  queue_src(8'(n));
                  queue_src(8'(n >> 8));
               end
            endcase
            queue_item(lcw_pkg::OP_TICK, 8'($urandom));
         end
      endcase
      // ignored once the decoder has stopped
      repeat (4) queue_item(1'($urandom), 8'($urandom));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(accepted == total_items && decoded_q.size() == 0) && cycle_count < CYCLE_LIMIT)
         @(negedge clock);

      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         // catch any stray result items behind the last one
         repeat (8) @(negedge clock);
         if (mismatches == 0 && decoded_q.size() == 0)
            $display("PASS");
         else
            $display("FAIL");
         $finish;
      end
   end

endmodule

### filelist.f
sv/lcw_pkg.sv
sv/lcw_decompressor.sv
tb/lcw_decompressor_test.sv
